### hdl/incremental_pid_step_defines.svh
// Assertion macros for the incremental PID step checker.
// Stand-alone header: no package or module needed.
`ifndef INCREMENTAL_PID_STEP_DEFINES_SVH
`define INCREMENTAL_PID_STEP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset
`define IPS_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the checker's own clk and arst_n
`define IPS_ASSERT(lbl, prop, msg) \
	`IPS_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### hdl/ips_pkg.sv
// Package for the incremental PID step: widths, codes and shared types.
// No dependencies.
`default_nettype none
package ips_pkg;

	localparam int DATA_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int HALF_W    = 16;
	localparam int MUL_W     = 18;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int IF_W      = 52;
	localparam int ACC_W     = 30;
	localparam int PD_SHIFT  = 8;
	localparam int I_SHIFT   = 25;

	localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 16'sd25600;
	localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -16'sd25600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP  = 3'd0,
		REG_GAIN_INTEG = 3'd1,
		REG_GAIN_DERIV = 3'd2,
		REG_PERIOD     = 3'd3,
		REG_DRIVE_MAX  = 3'd4,
		REG_DRIVE_MIN  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_MAX  = 2'd1,
		CLAMP_MIN  = 2'd2
	} clamp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KIT,
		ST_PD,
		ST_LO,
		ST_HI,
		ST_SUMI,
		ST_ACC,
		ST_CLAMP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_KIT,
		OP_PD,
		OP_LO,
		OP_HI,
		OP_SUMI,
		OP_ACC,
		OP_CLAMP
	} op_t;

	typedef struct packed {
		logic        [GAIN_W-1:0] gain_prop;
		logic        [GAIN_W-1:0] gain_integ;
		logic        [GAIN_W-1:0] gain_deriv;
		logic        [GAIN_W-1:0] period;
		logic signed [DATA_W-1:0] drive_max;
		logic signed [DATA_W-1:0] drive_min;
	} cfg_t;

endpackage
`default_nettype wire

### hdl/ips_if.sv
// Valid/ready channel interfaces for error samples and drive results.
// Depends on ips_pkg.
`default_nettype none
interface ips_in_if;
	import ips_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] err_sample;

	modport source (output valid, output err_sample, input ready);
	modport sink   (input valid, input err_sample, output ready);
endinterface

interface ips_out_if;
	import ips_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic        [1:0]        clamp_state;

	modport source (output valid, output drive, output clamp_state, input ready);
	modport sink   (input valid, input drive, input clamp_state, output ready);
endinterface
`default_nettype wire

### hdl/ips_cfg.sv
// Configuration register file: gains, period and drive limits.
// Depends on ips_pkg.
`default_nettype none
module ips_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [ips_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire  [ips_pkg::DATA_W-1:0]        cfg_wdata,
	output ips_pkg::cfg_t                     cfg
);
	import ips_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop  <= '0;
			cfg_q.gain_integ <= '0;
			cfg_q.gain_deriv <= '0;
			cfg_q.period     <= '0;
			cfg_q.drive_max  <= DRIVE_MAX_RST;
			cfg_q.drive_min  <= DRIVE_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN_PROP:  cfg_q.gain_prop  <= cfg_wdata;
				REG_GAIN_INTEG: cfg_q.gain_integ <= cfg_wdata;
				REG_GAIN_DERIV: cfg_q.gain_deriv <= cfg_wdata;
				REG_PERIOD:     cfg_q.period     <= cfg_wdata;
				REG_DRIVE_MAX:  cfg_q.drive_max  <= $signed(cfg_wdata);
				REG_DRIVE_MIN:  cfg_q.drive_min  <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### hdl/ips_ctrl.sv
// Sequencer for one PID step: handshakes and datapath operation codes.
// Depends on ips_pkg.
`default_nettype none
module ips_ctrl (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  wire         out_ready,
	output ips_pkg::op_t cmd
);
	import ips_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state, operation code and handshakes
	always_comb begin
		state_d  = state_q;
		cmd      = OP_NONE;
		in_ready = 1'b0;
		// retire a transaction the sink has taken
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = OP_LOAD;
					state_d = ST_KIT;
				end
			end
			ST_KIT: begin
				cmd     = OP_KIT;
				state_d = ST_PD;
			end
			ST_PD: begin
				cmd     = OP_PD;
				state_d = ST_LO;
			end
			ST_LO: begin
				cmd     = OP_LO;
				state_d = ST_HI;
			end
			ST_HI: begin
				cmd     = OP_HI;
				state_d = ST_SUMI;
			end
			ST_SUMI: begin
				cmd     = OP_SUMI;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd     = OP_ACC;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd         = OP_CLAMP;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hdl/ips_dp.sv
// Datapath for the PID step: shared 18x18 multiplier, accumulator, clamp.
// Depends on ips_pkg; sequenced by ips_ctrl.
`default_nettype none
module ips_dp (
	input  wire                               clk,
	input  wire                               arst_n,
	input  ips_pkg::op_t                      cmd,
	input  ips_pkg::cfg_t                     cfg,
	input  wire signed [ips_pkg::DATA_W-1:0]  err_sample,
	output logic signed [ips_pkg::DATA_W-1:0] drive,
	output logic [1:0]                        clamp_state
);
	import ips_pkg::*;

	logic signed [DATA_W-1:0]   e_q;
	logic signed [DATA_W-1:0]   last_err_q;
	logic signed [DATA_W-1:0]   last_drive_q;
	logic signed [DATA_W-1:0]   drive_q;
	clamp_t                     clamp_q;
	logic signed [DATA_W:0]     diff_q;
	logic signed [DATA_W:0]     sum_q;
	logic        [GAIN_W:0]     kpd_q;
	logic        [2*GAIN_W-1:0] kit_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [PROD_W-1:0]   ilo_q;
	logic signed [IF_W-1:0]     ifull_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [DATA_W:0]     e_ext;
	logic signed [DATA_W:0]     le_ext;
	logic signed [PROD_W-1:0]   pd_sh;
	logic signed [IF_W-1:0]     hi_ext;
	logic signed [IF_W-1:0]     lo_ext;
	logic signed [IF_W-1:0]     i_sh;
	logic signed [ACC_W-1:0]    ld_ext;
	logic signed [ACC_W-1:0]    max_ext;
	logic signed [ACC_W-1:0]    min_ext;
	logic signed [DATA_W-1:0]   y;
	clamp_t                     flag;

	// Pick multiplier operands for the current step
	always_comb begin
		case (cmd)
			OP_KIT: begin
				mul_a = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.gain_integ});
				mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.period});
			end
			OP_PD: begin
				mul_a = $signed({{(MUL_W-GAIN_W-1){1'b0}}, kpd_q});
				mul_b = $signed({{(MUL_W-DATA_W-1){diff_q[DATA_W]}}, diff_q});
			end
			OP_LO: begin
				mul_a = $signed({{(MUL_W-HALF_W){1'b0}}, kit_q[HALF_W-1:0]});
				mul_b = $signed({{(MUL_W-DATA_W-1){sum_q[DATA_W]}}, sum_q});
			end
			OP_HI: begin
				mul_a = $signed({{(MUL_W-HALF_W){1'b0}}, kit_q[2*GAIN_W-1:HALF_W]});
				mul_b = $signed({{(MUL_W-DATA_W-1){sum_q[DATA_W]}}, sum_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Operand extension, truncating shifts and the split integral product
	assign e_ext  = {err_sample[DATA_W-1], err_sample};
	assign le_ext = {last_err_q[DATA_W-1], last_err_q};
	assign pd_sh  = prod_q >>> PD_SHIFT;
	assign hi_ext = $signed({{(IF_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}) <<< HALF_W;
	assign lo_ext = $signed({{(IF_W-PROD_W){ilo_q[PROD_W-1]}}, ilo_q});
	assign i_sh   = ifull_q >>> I_SHIFT;
	assign ld_ext = $signed({{(ACC_W-DATA_W){last_drive_q[DATA_W-1]}}, last_drive_q});
	assign max_ext = $signed({{(ACC_W-DATA_W){cfg.drive_max[DATA_W-1]}}, cfg.drive_max});
	assign min_ext = $signed({{(ACC_W-DATA_W){cfg.drive_min[DATA_W-1]}}, cfg.drive_min});

	// Clamp: upper limit tested first
	always_comb begin
		if (acc_q > max_ext) begin
			y    = cfg.drive_max;
			flag = CLAMP_MAX;
		end else if (acc_q < min_ext) begin
			y    = cfg.drive_min;
			flag = CLAMP_MIN;
		end else begin
			y    = acc_q[DATA_W-1:0];
			flag = CLAMP_NONE;
		end
	end

	// Working registers, advanced one step per operation code
	always_ff @(posedge clk) begin
		case (cmd)
			OP_LOAD: begin
				e_q    <= err_sample;
				diff_q <= e_ext - le_ext;
				sum_q  <= e_ext + le_ext;
				kpd_q  <= {1'b0, cfg.gain_prop} + {1'b0, cfg.gain_deriv};
			end
			OP_KIT: begin
				prod_q <= mul_p;
			end
			OP_PD: begin
				kit_q  <= prod_q[2*GAIN_W-1:0];
				prod_q <= mul_p;
			end
			OP_LO: begin
				acc_q  <= ld_ext + $signed(pd_sh[ACC_W-1:0]);
				prod_q <= mul_p;
			end
			OP_HI: begin
				ilo_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_SUMI: begin
				ifull_q <= hi_ext + lo_ext;
			end
			OP_ACC: begin
				acc_q <= acc_q + $signed(i_sh[ACC_W-1:0]);
			end
			OP_CLAMP: begin
				drive_q <= y;
				clamp_q <= flag;
			end
			default: ;
		endcase
	end

	// Loop state: previous error and previous clamped drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			last_drive_q <= '0;
		end else if (cmd == OP_CLAMP) begin
			last_err_q   <= e_q;
			last_drive_q <= y;
		end
	end

	assign drive       = drive_q;
	assign clamp_state = clamp_q;

endmodule
`default_nettype wire

### hdl/incremental_pid_step.sv
// Incremental PID step: a sample runs the KIT, PD, LO, HI, SUMI, ACC and CLAMP
// states, using the single shared 18x18 multiplier four times per step plus the
// accumulate and clamp steps. A new sample is taken only in idle. The output
// register lets a result wait while the next sample is taken in; the clamp
// step waits for it to be free. Reset: gains and period 0, limits +/-100.0,
// previous error and drive 0; no clearing pass.
`default_nettype none
module incremental_pid_step (
	input  wire                            clk,
	input  wire                            arst_n,
	ips_in_if.sink                         in_ch,
	ips_out_if.source                      out_ch,
	input  wire                            cfg_we,
	input  wire [ips_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire [ips_pkg::DATA_W-1:0]      cfg_wdata
);
	import ips_pkg::*;

	cfg_t cfg;
	op_t  cmd;

	// Configuration registers
	ips_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Step sequencer
	ips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// Arithmetic and result register
	ips_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.err_sample  (in_ch.err_sample),
		.drive       (out_ch.drive),
		.clamp_state (out_ch.clamp_state)
	);

endmodule
`default_nettype wire

### hdl/ips_chk.sv
// Port-level checker for incremental_pid_step, attached by bind.
// Depends on ips_pkg and incremental_pid_step_defines.svh.
`default_nettype none
`include "incremental_pid_step_defines.svh"
module ips_chk (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [ips_pkg::DATA_W-1:0]    drive,
	input wire [1:0]                    clamp_state
);
	import ips_pkg::*;

	// A sample in flight blocks the next one
	`IPS_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready high during a step")

	// A fresh result must trace back to an accepted sample
	`IPS_ASSERT(a_result_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 8), "result latency")

	// Readiness returns only together with a result
	`IPS_ASSERT(a_ready_with_result, $rose(in_ready) |-> out_valid, "ready without result")

	// A stalled result holds its value
	`IPS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(drive) && $stable(clamp_state)), "stalled result changed")

endmodule

bind incremental_pid_step ips_chk u_ips_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.drive       (out_ch.drive),
	.clamp_state (out_ch.clamp_state)
);
`default_nettype wire
